FILE: hdl/rtcu_pkg.sv
// Shared types, constants, microcode encoding and calendar helpers of the RTC tracker.
package rtcu_pkg;

  localparam int unsigned PcW = 4;
  localparam int unsigned CntW = 8;
  localparam int unsigned AccW = 32;

  localparam logic [31:0] SecPerDay = 32'd86400;
  localparam logic [31:0] SecPerHour = 32'd3600;
  localparam logic [31:0] SecPerMin = 32'd60;
  localparam logic [31:0] SecPerLeapYear = 32'(366 * 86400);
  localparam logic [31:0] SecPerYear = 32'(365 * 86400);

  localparam logic [7:0] MaskSec = 8'h7F;
  localparam logic [7:0] MaskMin = 8'h7F;
  localparam logic [7:0] MaskHour = 8'h3F;
  localparam logic [7:0] MaskDay = 8'h3F;
  localparam logic [7:0] MaskMonth = 8'h1F;
  localparam logic [7:0] MaskYear = 8'hFF;

  // Offset from 1970 to 2000, and the years 2000+yy for the century rules.
  localparam logic [7:0] YearBase = 8'd30;
  localparam logic [7:0] YyCentury = 8'd100;
  localparam logic [7:0] YearIdxCentury = 8'd130;

  // Program steps.
  localparam logic [PcW-1:0] StWait = 4'd0;
  localparam logic [PcW-1:0] StDecide = 4'd1;
  localparam logic [PcW-1:0] StYears = 4'd2;
  localparam logic [PcW-1:0] StMStart = 4'd3;
  localparam logic [PcW-1:0] StMonths = 4'd4;
  localparam logic [PcW-1:0] StDay = 4'd5;
  localparam logic [PcW-1:0] StHour = 4'd6;
  localparam logic [PcW-1:0] StFast = 4'd7;
  localparam logic [PcW-1:0] StMinSec = 4'd8;
  localparam logic [PcW-1:0] StEmit = 4'd9;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_CLR,
    OP_ADD_YEAR,
    OP_CNT_ONE,
    OP_ADD_MONTH,
    OP_ADD_DAY,
    OP_ADD_HOUR,
    OP_ADD_MINSEC,
    OP_FAST,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_NO_IN,
    CND_NEAR,
    CND_YEAR_DONE,
    CND_MON_DONE,
    CND_OUT_BUSY
  } cond_e;

  // op runs when cond is false and the step falls to nxt; a true cond jumps to jmp.
  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] jmp;
    logic [PcW-1:0] nxt;
  } ucode_t;

  typedef struct packed {
    logic near;
    logic year_done;
    logic mon_done;
    logic out_busy;
  } dp_flags_t;

  function automatic logic [7:0] bcd_dec(input logic [7:0] raw, input logic [7:0] mask);
    logic [7:0] v;
    v = raw & mask;
    return ({4'd0, v[7:4]} * 8'd10) + {4'd0, v[3:0]};
  endfunction

  // Year index k counts from 1970; leap when 1970+k is divisible by four, except 2100.
  function automatic logic [31:0] year_secs(input logic [CntW-1:0] k);
    return ((k[1:0] == 2'd2) && (k != YearIdxCentury)) ? SecPerLeapYear : SecPerYear;
  endfunction

  function automatic logic [31:0] month_secs(input logic [4:0] m, input logic leap);
    logic [31:0] days;
    case (m)
      5'd4, 5'd6, 5'd9, 5'd11: days = 32'd30;
      5'd2:                    days = leap ? 32'd29 : 32'd28;
      default:                 days = 32'd31;
    endcase
    return days * SecPerDay;
  endfunction

endpackage

FILE: hdl/rtcu_ucode_rom.sv
// Microcode table of the RTC tracker sequencer.
module rtcu_ucode_rom (
  input  logic [rtcu_pkg::PcW-1:0] pc_i,
  output rtcu_pkg::ucode_t         word_o
);
  import rtcu_pkg::*;

  always_comb begin
    unique case (pc_i)
      StWait:   word_o = '{op: OP_LOAD,       cond: CND_NO_IN,     jmp: StWait,   nxt: StDecide};
      StDecide: word_o = '{op: OP_CLR,        cond: CND_NEAR,      jmp: StFast,   nxt: StYears};
      StYears:  word_o = '{op: OP_ADD_YEAR,   cond: CND_YEAR_DONE, jmp: StMStart, nxt: StYears};
      StMStart: word_o = '{op: OP_CNT_ONE,    cond: CND_NEVER,     jmp: StMonths, nxt: StMonths};
      StMonths: word_o = '{op: OP_ADD_MONTH,  cond: CND_MON_DONE,  jmp: StDay,    nxt: StMonths};
      StDay:    word_o = '{op: OP_ADD_DAY,    cond: CND_NEVER,     jmp: StHour,   nxt: StHour};
      StHour:   word_o = '{op: OP_ADD_HOUR,   cond: CND_NEVER,     jmp: StMinSec, nxt: StMinSec};
      StFast:   word_o = '{op: OP_FAST,       cond: CND_NEVER,     jmp: StEmit,   nxt: StEmit};
      StMinSec: word_o = '{op: OP_ADD_MINSEC, cond: CND_NEVER,     jmp: StEmit,   nxt: StEmit};
      StEmit:   word_o = '{op: OP_EMIT,       cond: CND_OUT_BUSY,  jmp: StEmit,   nxt: StWait};
      default:  word_o = '{op: OP_LOAD,       cond: CND_NO_IN,     jmp: StWait,   nxt: StWait};
    endcase
  end

endmodule

FILE: hdl/rtcu_datapath.sv
// Datapath of the RTC tracker: decoded fields, accumulator, loop counter and output register.
module rtcu_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rtcu_pkg::op_e        op_i,
  input  logic                 op_en_i,
  input  logic [47:0]          in_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [31:0]          out_seconds_o,
  output logic                 out_resynced_o,
  output rtcu_pkg::dp_flags_t  flags_o
);
  import rtcu_pkg::*;

  logic [6:0]          sec_q, min_q;
  logic [5:0]          hour_q, day_q;
  logic [4:0]          month_q;
  logic [7:0]          yy_q;
  logic [AccW-1:0]     acc_q;
  logic [CntW-1:0]     cnt_q;
  logic                rsync_q;
  logic [6:0]          last_q;
  logic [31:0]         count_q;
  logic                out_valid_q;
  logic [31:0]         out_data_q;
  logic                out_user_q;
  logic [7:0]          last_inc;
  logic                is_next;
  logic                yy_leap;
  logic [5:0]          day_m1;

  assign last_inc = {1'b0, last_q} + 8'd1;
  assign is_next  = ({1'b0, sec_q} == last_inc);
  assign yy_leap  = (yy_q[1:0] == 2'd0) && (yy_q != YyCentury);
  assign day_m1   = (day_q > 6'd1) ? (day_q - 6'd1) : 6'd0;

  assign flags_o.near      = (sec_q == last_q) || is_next;
  assign flags_o.year_done = (cnt_q == (yy_q + YearBase));
  assign flags_o.mon_done  = (cnt_q >= {3'd0, month_q});
  assign flags_o.out_busy  = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (op_en_i) begin
      case (op_i)
        OP_LOAD: begin
          sec_q   <= 7'(bcd_dec(in_data_i[7:0], MaskSec));
          min_q   <= 7'(bcd_dec(in_data_i[15:8], MaskMin));
          hour_q  <= 6'(bcd_dec(in_data_i[23:16], MaskHour));
          day_q   <= 6'(bcd_dec(in_data_i[31:24], MaskDay));
          month_q <= 5'(bcd_dec(in_data_i[39:32], MaskMonth));
          yy_q    <= bcd_dec(in_data_i[47:40], MaskYear);
        end
        OP_CLR: begin
          acc_q   <= '0;
          cnt_q   <= '0;
          rsync_q <= 1'b1;
        end
        OP_ADD_YEAR: begin
          acc_q <= acc_q + year_secs(cnt_q);
          cnt_q <= cnt_q + 1'b1;
        end
        OP_CNT_ONE: cnt_q <= CntW'(1);
        OP_ADD_MONTH: begin
          acc_q <= acc_q + month_secs(cnt_q[4:0], yy_leap);
          cnt_q <= cnt_q + 1'b1;
        end
        OP_ADD_DAY:    acc_q <= acc_q + 32'({26'd0, day_m1} * SecPerDay);
        OP_ADD_HOUR:   acc_q <= acc_q + 32'({26'd0, hour_q} * SecPerHour);
        OP_ADD_MINSEC: acc_q <= acc_q + 32'({25'd0, min_q} * SecPerMin) + {25'd0, sec_q};
        OP_FAST: begin
          acc_q   <= count_q + {31'd0, is_next};
          rsync_q <= 1'b0;
        end
        OP_EMIT: begin
          out_data_q <= acc_q;
          out_user_q <= rsync_q;
        end
        default: ;
      endcase
    end
  end

  // Tracking state and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (op_en_i && (op_i == OP_EMIT)) begin
      last_q      <= sec_q;
      count_q     <= acc_q;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_seconds_o  = out_data_q;
  assign out_resynced_o = out_user_q;

endmodule

FILE: hdl/rtc_bcd_to_unix_time_tracker_unit.sv
// Top level of the BCD RTC snapshot to Unix seconds tracker.
//
// Usage: each item on the slave stream is one snapshot of the raw BCD clock
// registers (seconds, minutes, hours, day, month, two-digit year). For every
// item one result leaves on the master stream: the running Unix seconds count
// in tdata and a resync flag in tuser.
// When the decoded second equals the last one, or is exactly one more, the
// held count is reported as is or plus one, through the decide, fast and emit
// steps, after which the sequencer waits for the next item. Otherwise the count
// is rebuilt from the calendar by a microcoded sequencer that adds one year per
// cycle from 1970 and one month per cycle.
// One item is worked on at a time; tready is high only while the sequencer
// waits for input, and a result waiting in the output register does not keep
// the next item from being taken.
// Reset clears the count, the last second and the output valid.
// A stalled receiver holds the result; the sequencer waits in its final step
// until the output register is free.
module rtc_bcd_to_unix_time_tracker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // seconds_bcd[7:0], minutes_bcd[15:8], hours_bcd[23:16], day_bcd[31:24],
  // month_bcd[39:32], year_bcd[47:40]
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // unix_seconds[31:0]
  output logic [31:0] m_axis_tdata_o,
  // resynced[0]
  output logic        m_axis_tuser_o
);
  import rtcu_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  ucode_t         word;
  dp_flags_t      flags;
  logic           cond_true;

  rtcu_ucode_rom u_rom (
    .pc_i   (pc_q),
    .word_o (word)
  );

  always_comb begin
    case (word.cond)
      CND_NEVER:     cond_true = 1'b0;
      CND_NO_IN:     cond_true = !s_axis_tvalid_i;
      CND_NEAR:      cond_true = flags.near;
      CND_YEAR_DONE: cond_true = flags.year_done;
      CND_MON_DONE:  cond_true = flags.mon_done;
      CND_OUT_BUSY:  cond_true = flags.out_busy;
      default:       cond_true = 1'b0;
    endcase
    pc_d = cond_true ? word.jmp : word.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StWait;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign s_axis_tready_o = (pc_q == StWait);

  rtcu_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (word.op),
    .op_en_i        (!cond_true),
    .in_data_i      (s_axis_tdata_i),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_seconds_o  (m_axis_tdata_o),
    .out_resynced_o (m_axis_tuser_o),
    .flags_o        (flags)
  );

endmodule

FILE: tb/sv/rtcu_epoch_checker.sv
`timescale 1ns / 1ps
// Checker of the RTC tracker: predicts the Unix seconds of each snapshot and compares results.
module rtcu_epoch_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [47:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic        m_tuser_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          results_o,
  output int          resyncs_o
);
  import rtcu_pkg::*;

  typedef struct packed {
    logic [31:0] unix_seconds;
    logic        resynced;
  } epoch_result_t;

  epoch_result_t epoch_due_q[$];
  epoch_result_t due;
  epoch_result_t next_due;

  // Own copy of the tracker state.
  logic [6:0]  last_sec;
  logic [31:0] epoch;

  int unsigned sec, min, hour, day, month, yy;
  int          mismatches;
  int          results;
  int          resyncs;

  assign mismatches_o = mismatches;
  assign results_o    = results;
  assign resyncs_o    = resyncs;

  function automatic int unsigned bcd_value(input logic [7:0] raw, input logic [7:0] mask);
    logic [7:0] v;
    v = raw & mask;
    return v[7:4] * 10 + v[3:0];
  endfunction

  function automatic bit is_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return is_leap(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // Rebuild the count from 1970; every sum wraps at 32 bits.
  function automatic logic [31:0] epoch_from_calendar(input int unsigned s, input int unsigned mi,
                                                      input int unsigned h, input int unsigned d,
                                                      input int unsigned mo,
                                                      input int unsigned y2);
    logic [31:0] total;
    int unsigned year;
    year  = 2000 + y2;
    total = '0;
    for (int unsigned y = 1970; y < year; y++) begin
      total += (is_leap(y) ? 366 : 365) * SecPerDay;
    end
    for (int unsigned k = 1; k < mo; k++) begin
      total += days_in_month(k, year) * SecPerDay;
    end
    if (d > 1) begin
      total += (d - 1) * SecPerDay;
    end
    total += h * SecPerHour;
    total += mi * SecPerMin;
    total += s;
    return total;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_due_q.delete();
      last_sec   = '0;
      epoch      = '0;
      mismatches = 0;
      results    = 0;
      resyncs    = 0;
      pending_o  = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        results++;
        if (epoch_due_q.size() == 0) begin
          report_mismatch("result with no item pending", 32'h0, m_tdata_i);
        end else begin
          due = epoch_due_q.pop_front();
          if (m_tdata_i !== due.unix_seconds) begin
            report_mismatch("unix_seconds", due.unix_seconds, m_tdata_i);
          end
          if (m_tuser_i !== due.resynced) begin
            report_mismatch("resynced", 32'(due.resynced), 32'(m_tuser_i));
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        sec   = bcd_value(s_tdata_i[7:0], MaskSec);
        min   = bcd_value(s_tdata_i[15:8], MaskMin);
        hour  = bcd_value(s_tdata_i[23:16], MaskHour);
        day   = bcd_value(s_tdata_i[31:24], MaskDay);
        month = bcd_value(s_tdata_i[39:32], MaskMonth);
        yy    = bcd_value(s_tdata_i[47:40], MaskYear);
        next_due.resynced = 1'b0;
        if (sec == last_sec) begin
          // hold the count
        end else if (sec == last_sec + 1) begin
          epoch = epoch + 32'd1;
        end else begin
          epoch = epoch_from_calendar(sec, min, hour, day, month, yy);
          next_due.resynced = 1'b1;
          resyncs++;
        end
        last_sec = sec[6:0];
        next_due.unix_seconds = epoch;
        epoch_due_q.push_back(next_due);
      end
      pending_o = epoch_due_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_rtc_bcd_to_unix_time_tracker_unit.sv
`timescale 1ns / 1ps
// Testbench top: drives BCD clock snapshots into the Unix time tracker and gives the verdict.
module tb_rtc_bcd_to_unix_time_tracker_unit;
  import rtcu_pkg::*;

  localparam int RandomItems   = 1500;
  localparam int CycleLimit    = 2500000;
  localparam int DrainCycles   = 300;
  localparam int HoldOffCycles = 400;

  logic        clk;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tuser;

  int mismatches;
  int pending;
  int results;
  int resyncs;
  int sent;
  int burst_left;
  int cycle_count;
  int run_len;
  int pick;
  bit held_off;
  int rx_mode;
  int rx_stretch;

  // Running calendar of the well-formed runs.
  int unsigned cal_sec, cal_min, cal_hour, cal_day, cal_month, cal_year;

  rtc_bcd_to_unix_time_tracker_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  rtcu_epoch_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tuser_i   (m_tuser),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .results_o   (results),
    .resyncs_o   (resyncs)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] to_bcd(input int unsigned n);
    return {4'(n / 10), 4'(n % 10)};
  endfunction

  function automatic logic [47:0] snapshot(input logic [7:0] s, input logic [7:0] mi,
                                           input logic [7:0] h, input logic [7:0] d,
                                           input logic [7:0] mo, input logic [7:0] y);
    return {y, mo, d, h, mi, s};
  endfunction

  // Current calendar as raw registers, now and then with junk in the ignored bits.
  function automatic logic [47:0] calendar_snapshot();
    logic [7:0] junk;
    junk = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00;
    return snapshot(to_bcd(cal_sec) | (junk & ~MaskSec), to_bcd(cal_min) | (junk & ~MaskMin),
                    to_bcd(cal_hour) | (junk & ~MaskHour), to_bcd(cal_day) | (junk & ~MaskDay),
                    to_bcd(cal_month) | (junk & ~MaskMonth), to_bcd(cal_year));
  endfunction

  task automatic new_calendar();
    cal_sec   = $urandom_range(0, 59);
    cal_min   = $urandom_range(0, 59);
    cal_hour  = $urandom_range(0, 23);
    cal_day   = $urandom_range(1, 28);
    cal_month = $urandom_range(1, 12);
    cal_year  = $urandom_range(0, 99);
  endtask

  // Advance one second; days roll over at 28 to keep every date valid.
  task automatic tick_calendar();
    cal_sec++;
    if (cal_sec == 60) begin
      cal_sec = 0;
      cal_min++;
    end
    if (cal_min == 60) begin
      cal_min = 0;
      cal_hour++;
    end
    if (cal_hour == 24) begin
      cal_hour = 0;
      cal_day++;
    end
    if (cal_day == 29) begin
      cal_day = 1;
      cal_month++;
    end
    if (cal_month == 13) begin
      cal_month = 1;
      cal_year = (cal_year + 1) % 100;
    end
  endtask

  // Offer one item, in bursts with random gaps, and hold it until taken.
  task automatic offer_snapshot(input logic [47:0] item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending == 0);
    burst_left = 0;
  endtask

  initial begin
    rst_n      = 1'b0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    burst_left = 0;
    sent       = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: hold and step from reset, masks, non-BCD digits, rollover, leap rules, wrap.
    offer_snapshot(snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    offer_snapshot(snapshot(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    offer_snapshot(snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    offer_snapshot(snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    offer_snapshot(snapshot(8'h80, 8'h80, 8'hC0, 8'hC0, 8'hE0, 8'h00));
    offer_snapshot(snapshot(8'h58, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99));
    offer_snapshot(snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99));
    offer_snapshot(snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00));
    offer_snapshot(snapshot(8'h09, 8'h30, 8'h12, 8'h29, 8'h02, 8'h96));
    offer_snapshot(snapshot(8'h0A, 8'h30, 8'h12, 8'h29, 8'h02, 8'h96));
    offer_snapshot(snapshot(8'h0F, 8'h30, 8'h12, 8'h29, 8'h02, 8'h96));
    offer_snapshot(snapshot(8'h10, 8'h30, 8'h12, 8'h29, 8'h02, 8'h96));
    offer_snapshot(snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'hA0));
    offer_snapshot(snapshot(8'h30, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00));
    offer_snapshot(snapshot(8'h20, 8'h00, 8'h00, 8'h01, 8'h03, 8'h04));
    offer_snapshot(snapshot(8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    offer_snapshot(snapshot(8'h15, 8'h00, 8'h00, 8'h01, 8'h13, 8'h05));
    offer_snapshot(snapshot(8'h25, 8'h00, 8'h00, 8'h01, 8'h19, 8'h05));
    offer_snapshot(snapshot(8'h45, 8'h7F, 8'h3F, 8'h01, 8'h01, 8'h06));
    offer_snapshot(snapshot(8'h02, 8'h14, 8'h28, 8'h07, 8'h02, 8'h6A));
    offer_snapshot(snapshot(8'h07, 8'h14, 8'h03, 8'h19, 8'h01, 8'h38));
    offer_snapshot(snapshot(8'h08, 8'h14, 8'h03, 8'h19, 8'h01, 8'h38));
    offer_snapshot(snapshot(8'h15, 8'h28, 8'h06, 8'h07, 8'h02, 8'hA6));
    offer_snapshot(snapshot(8'h16, 8'h28, 8'h06, 8'h07, 8'h02, 8'hA6));
    drain_results();

    // Random: mostly ticking clocks with random dates, some raw noise.
    while (sent < RandomItems + 24) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) offer_snapshot(48'({$urandom, $urandom}));
      end else begin
        new_calendar();
        run_len = $urandom_range(4, 60);
        repeat (run_len) begin
          offer_snapshot(calendar_snapshot());
          pick = $urandom_range(0, 99);
          if (pick < 45) begin
            // keep the same second
          end else if (pick < 95) begin
            tick_calendar();
          end else begin
            new_calendar();
          end
        end
      end
      if ($urandom_range(0, 19) == 0) begin
        drain_results();
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d clock snapshots; %0d results checked, %0d of them rebuilt from the date.",
             sent, results, resyncs);
    $display("Covered register masks, non-BCD digits, leap and century years and count wrap.");
    if (mismatches == 0) begin
      $display("rtc_bcd_to_unix_time_tracker_unit test passed");
    end else begin
      $display("rtc_bcd_to_unix_time_tracker_unit test failed");
    end
    $finish;
  end

  // Receiver: stall in stretches of changing patterns, with one long hold-off.
  initial begin
    m_tready = 1'b0;
    held_off = 1'b0;
    wait (rst_n);
    forever begin
      rx_mode    = $urandom_range(0, 3);
      rx_stretch = $urandom_range(8, 200);
      repeat (rx_stretch) begin
        @(negedge clk);
        if (!held_off && results >= 200) begin
          held_off = 1'b1;
          m_tready <= 1'b0;
          repeat (HoldOffCycles - 1) @(negedge clk);
        end else begin
          case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 4) == 0);
            default: m_tready <= ((cycle_count % 4) == 0);
          endcase
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", CycleLimit);
    $display("rtc_bcd_to_unix_time_tracker_unit test failed");
    $finish;
  end

endmodule
